FILE: rtl/core/bzr_pkg.sv
package bzr_pkg;

  localparam int MAX_SEGMENTS_DEF = 4;

  localparam int FREQ_W     = 16;
  localparam int LEN_W      = 16;
  localparam int DUTY_W     = 7;
  localparam int VOL_W      = 7;
  localparam int TIME_W     = 32;
  localparam int CUE_W      = 4;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int BEEP_HZ      = 2700;
  localparam int DUTY_FULL    = 127;
  localparam int VOL_MAX      = 100;
  localparam int MIN_TOTAL_MS = 50;
  localparam int MAX_LEN_MS   = 65535;

  localparam int NUM_CUES = 9;
  localparam int CUE_SEGS = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_CUE  = 2'd1;
  localparam logic [OP_W-1:0] OP_BEEP = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PASSIVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT  = 2'd2;

  localparam logic [CUE_W-1:0] CUE_FIRST = 4'd1;
  localparam logic [CUE_W-1:0] CUE_LAST  = 4'd9;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [TIME_W-1:0] now_ms;
    logic [CUE_W-1:0]  cue;
    logic [TIME_W-1:0] beep_ms;
  } in_item_t;

  typedef struct packed {
    logic              playing;
    logic [FREQ_W-1:0] pwm_freq_hz;
    logic [DUTY_W-1:0] pwm_duty;
    logic              pin_level;
  } out_item_t;

  typedef struct packed {
    logic [VOL_W-1:0]  volume;
    logic              passive_mode;
    logic              pin_inverted;
    logic [DUTY_W-1:0] duty;
  } cfg_t;

  typedef logic [DUTY_W-1:0] duty_tab_t [2**VOL_W];
  typedef logic [FREQ_W-1:0] cue_freq_t [NUM_CUES][CUE_SEGS];
  typedef logic [LEN_W-1:0]  cue_len_t  [NUM_CUES][CUE_SEGS];
  typedef logic [1:0]        cue_cnt_t  [NUM_CUES];
  typedef logic [LEN_W-1:0]  cue_tot_t  [NUM_CUES];

  localparam cue_freq_t CUE_FREQ = '{
    '{16'd2700, 16'd0,    16'd2700},
    '{16'd2300, 16'd2500, 16'd2700},
    '{16'd2700, 16'd2400, 16'd2100},
    '{16'd2700, 16'd0,    16'd0},
    '{16'd3100, 16'd0,    16'd0},
    '{16'd2700, 16'd3300, 16'd0},
    '{16'd2700, 16'd0,    16'd0},
    '{16'd2200, 16'd0,    16'd0},
    '{16'd2700, 16'd0,    16'd0}
  };

  localparam cue_len_t CUE_LEN = '{
    '{16'd70,  16'd60,  16'd70},
    '{16'd80,  16'd80,  16'd340},
    '{16'd150, 16'd150, 16'd200},
    '{16'd200, 16'd0,   16'd0},
    '{16'd90,  16'd0,   16'd0},
    '{16'd120, 16'd280, 16'd0},
    '{16'd280, 16'd0,   16'd0},
    '{16'd280, 16'd0,   16'd0},
    '{16'd120, 16'd0,   16'd0}
  };

  localparam cue_cnt_t CUE_COUNT = '{2'd3, 2'd3, 2'd3, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1};

  function automatic duty_tab_t duty_table();
    duty_tab_t t;
    for (int i = 0; i < 2**VOL_W; i++) begin
      t[i] = DUTY_W'((i * DUTY_FULL) / VOL_MAX);
    end
    return t;
  endfunction

  // single-tone length used for a cue in on/off mode
  function automatic cue_tot_t cue_total_table();
    cue_tot_t t;
    int       sum;
    for (int k = 0; k < NUM_CUES; k++) begin
      sum = 0;
      for (int i = 0; i < CUE_SEGS; i++) begin
        if (i < int'(CUE_COUNT[k])) sum += int'(CUE_LEN[k][i]);
      end
      if (sum < MIN_TOTAL_MS) sum = MIN_TOTAL_MS;
      if (sum > MAX_LEN_MS) sum = MAX_LEN_MS;
      t[k] = LEN_W'(sum);
    end
    return t;
  endfunction

  localparam duty_tab_t DUTY_TABLE = duty_table();
  localparam cue_tot_t  CUE_TOTAL  = cue_total_table();

endpackage

FILE: rtl/core/buzzer_tone_cue_sequencer.sv
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   in_data    (bzr_pkg::in_item_t)
// out       output     out_valid / out_stall out_data   (bzr_pkg::out_item_t)
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item per cycle sustained while out_stall stays low; a taken item waits in
// the input register, then the sequencer update loads the result register that
// drives out_data; the state update is a 32-bit subtract and compare plus a
// segment table lookup
// rst_n is synchronous; cfg_ready is always high
// in_stall rises only while the result register holds an item that out_stall
// keeps waiting, and an item is always free to enter the empty input register
module buzzer_tone_cue_sequencer #(
  parameter int MAX_SEGMENTS = bzr_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bzr_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bzr_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bzr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bzr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bzr_pkg::*;

  in_item_t  in_item_r;
  logic      in_vld_r, in_vld_nxt;
  out_item_t out_item_r;
  logic      out_vld_r, out_vld_nxt;
  out_item_t result;
  cfg_t      cfg;
  logic      fire;
  logic      take;

  assign cfg_ready = 1'b1;

  bzr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bzr_seq #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  // the held item moves on when the result register is empty or draining
  assign fire     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !fire;
  assign take     = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (take)      in_vld_nxt = 1'b1;
    else if (fire) in_vld_nxt = 1'b0;
    out_vld_nxt = out_vld_r;
    if (fire)           out_vld_nxt = 1'b1;
    else if (!out_stall) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) in_item_r  <= in_data;
    if (fire) out_item_r <= result;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("processed item produced no result");

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !fire) |=> in_vld_r)
    else $error("held item dropped before processing");

endmodule

FILE: rtl/core/bzr_cfg.sv
module bzr_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [bzr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bzr_pkg::CFG_DATA_W-1:0] cfg_data,
  output bzr_pkg::cfg_t                  cfg
);
  import bzr_pkg::*;

  logic [VOL_W-1:0] volume_r, volume_nxt;
  logic             passive_r, passive_nxt;
  logic             invert_r, invert_nxt;

  always_comb begin
    volume_nxt  = volume_r;
    passive_nxt = passive_r;
    invert_nxt  = invert_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_VOLUME: begin
          volume_nxt = (cfg_data > CFG_DATA_W'(VOL_MAX)) ? VOL_W'(VOL_MAX) : VOL_W'(cfg_data);
        end
        CFG_PASSIVE: passive_nxt = cfg_data[0];
        CFG_INVERT:  invert_nxt  = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r  <= VOL_W'(VOL_MAX);
      passive_r <= 1'b1;
      invert_r  <= 1'b0;
    end else begin
      volume_r  <= volume_nxt;
      passive_r <= passive_nxt;
      invert_r  <= invert_nxt;
    end
  end

  assign cfg.volume       = volume_r;
  assign cfg.passive_mode = passive_r;
  assign cfg.pin_inverted = invert_r;
  assign cfg.duty         = DUTY_TABLE[volume_r];

endmodule

FILE: rtl/core/bzr_seq.sv
module bzr_seq #(
  parameter int MAX_SEGMENTS = bzr_pkg::MAX_SEGMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  bzr_pkg::in_item_t  item,
  input  bzr_pkg::cfg_t      cfg,
  output bzr_pkg::out_item_t result
);
  import bzr_pkg::*;

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  logic              busy_r, busy_nxt;
  logic [FREQ_W-1:0] step_freq_r [MAX_SEGMENTS];
  logic [FREQ_W-1:0] step_freq_nxt [MAX_SEGMENTS];
  logic [LEN_W-1:0]  step_len_r [MAX_SEGMENTS];
  logic [LEN_W-1:0]  step_len_nxt [MAX_SEGMENTS];
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  now_r, now_nxt;
  logic [TIME_W-1:0] began_r, began_nxt;
  logic [FREQ_W-1:0] tone_freq_r, tone_freq_nxt;
  logic [DUTY_W-1:0] tone_duty_r, tone_duty_nxt;
  logic              drive_r, drive_nxt;

  logic [TIME_W-1:0] elapsed;
  logic [LEN_W-1:0]  cur_len;
  logic [CUE_W-1:0]  k;
  logic [LEN_W-1:0]  beep_len;
  logic              req_ok;
  logic              do_start;
  logic              go_silent;
  logic [FREQ_W-1:0] start_f;

  assign elapsed  = item.now_ms - began_r;
  assign cur_len  = step_len_r[now_r[IDX_W-1:0]];
  assign k        = item.cue - CUE_FIRST;
  assign beep_len = (item.beep_ms > TIME_W'(MAX_LEN_MS)) ? LEN_W'(MAX_LEN_MS)
                                                         : item.beep_ms[LEN_W-1:0];
  assign req_ok   = (cfg.volume != '0);

  always_comb begin
    busy_nxt      = busy_r;
    step_freq_nxt = step_freq_r;
    step_len_nxt  = step_len_r;
    total_nxt     = total_r;
    now_nxt       = now_r;
    began_nxt     = began_r;
    tone_freq_nxt = tone_freq_r;
    tone_duty_nxt = tone_duty_r;
    drive_nxt     = drive_r;
    do_start      = 1'b0;
    go_silent     = 1'b0;
    start_f       = '0;
    if (fire) begin
      case (item.operation)
        OP_TICK: begin
          if (busy_r && (now_r < CNT_W'(MAX_SEGMENTS)) && (item.now_ms >= began_r) &&
              (elapsed >= TIME_W'(cur_len))) begin
            now_nxt = now_r + 1'b1;
            if (now_nxt >= total_r) begin
              go_silent = 1'b1;
              busy_nxt  = 1'b0;
              total_nxt = '0;
            end else begin
              do_start = 1'b1;
              start_f  = step_freq_r[now_nxt[IDX_W-1:0]];
            end
          end
        end
        OP_CUE: begin
          if ((item.cue inside {[CUE_FIRST:CUE_LAST]}) && req_ok) begin
            now_nxt  = '0;
            busy_nxt = 1'b1;
            do_start = 1'b1;
            if (cfg.passive_mode) begin
              for (int i = 0; i < CUE_SEGS; i++) begin
                step_freq_nxt[i] = CUE_FREQ[k][i];
                step_len_nxt[i]  = CUE_LEN[k][i];
              end
              total_nxt = CNT_W'(CUE_COUNT[k]);
              start_f   = CUE_FREQ[k][0];
            end else begin
              step_freq_nxt[0] = FREQ_W'(BEEP_HZ);
              step_len_nxt[0]  = CUE_TOTAL[k];
              total_nxt        = CNT_W'(1);
              start_f          = FREQ_W'(BEEP_HZ);
            end
          end
        end
        OP_BEEP: begin
          if ((item.beep_ms != '0) && req_ok) begin
            step_freq_nxt[0] = FREQ_W'(BEEP_HZ);
            step_len_nxt[0]  = beep_len;
            total_nxt        = CNT_W'(1);
            now_nxt          = '0;
            busy_nxt         = 1'b1;
            do_start         = 1'b1;
            start_f          = FREQ_W'(BEEP_HZ);
          end
        end
        default: ;
      endcase
    end
    if (do_start) begin
      began_nxt = item.now_ms;
      if (start_f == '0) begin
        go_silent = 1'b1;
      end else if (cfg.passive_mode) begin
        tone_freq_nxt = start_f;
        tone_duty_nxt = cfg.duty;
      end else begin
        drive_nxt = ~cfg.pin_inverted;
      end
    end
    // the mode in force at this moment picks which output goes quiet
    if (go_silent) begin
      if (cfg.passive_mode) tone_duty_nxt = '0;
      else                  drive_nxt     = cfg.pin_inverted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      total_r     <= '0;
      now_r       <= '0;
      began_r     <= '0;
      tone_freq_r <= FREQ_W'(BEEP_HZ);
      tone_duty_r <= '0;
      drive_r     <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      total_r     <= total_nxt;
      now_r       <= now_nxt;
      began_r     <= began_nxt;
      tone_freq_r <= tone_freq_nxt;
      tone_duty_r <= tone_duty_nxt;
      drive_r     <= drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_freq_r <= step_freq_nxt;
    step_len_r  <= step_len_nxt;
  end

  assign result.playing     = busy_nxt;
  assign result.pwm_freq_hz = tone_freq_nxt;
  assign result.pwm_duty    = tone_duty_nxt;
  assign result.pin_level   = drive_nxt;

endmodule
